/* hdl/lic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// constants shared by the line intersection block
// no dependencies
package lic_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int DIV_STEPS = PROD_W + FRAC_BITS;
  localparam logic [COEF_W-1:0] EPS_RESET = COEF_W'(1);
  localparam logic [COEF_W-1:0] Q_MAX_POS = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] Q_MAX_NEG = {1'b1, {(COEF_W-1){1'b0}}};
endpackage
`default_nettype wire

/* hdl/line_intersection_cramer.sv */
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle while the result side does not stall; 3 stages form the determinants, then a
// restoring divider of 80 one-bit stages per coordinate, then the output register
// a stall on the result side freezes every stage together
// reset: synchronous active-low rst_n empties the pipe and sets eps_r to 1
module line_intersection_cramer import lic_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // line1_a, line1_b, line1_c, line2_a, line2_b, line2_c
  input  wire logic [191:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // cross_x, cross_y
  output logic [63:0]        out_tdata,
  // found, overflow
  output logic [1:0]         out_tuser
);

  logic [COEF_W-1:0] eps_r;
  logic              en;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // stage 1: products
  logic                     s1_v_r;
  logic signed [PROD_W-1:0] p_ab_r, p_ba_r, p_bc_r, p_cb_r, p_ca_r, p_ac_r;
  logic signed [COEF_W-1:0] a1, b1, c1, a2, b2, c2;

  assign a1 = in_tdata[31:0];
  assign b1 = in_tdata[63:32];
  assign c1 = in_tdata[95:64];
  assign a2 = in_tdata[127:96];
  assign b2 = in_tdata[159:128];
  assign c2 = in_tdata[191:160];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ab_r <= a1 * b2;
      p_ba_r <= b1 * a2;
      p_bc_r <= b1 * c2;
      p_cb_r <= c1 * b2;
      p_ca_r <= c1 * a2;
      p_ac_r <= a1 * c2;
    end
  end

  // stage 2: exact differences
  logic                     s2_v_r;
  logic signed [PROD_W:0]   d_r, dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= {p_ab_r[PROD_W-1], p_ab_r} - {p_ba_r[PROD_W-1], p_ba_r};
      dx_r <= {p_bc_r[PROD_W-1], p_bc_r} - {p_cb_r[PROD_W-1], p_cb_r};
      dy_r <= {p_ca_r[PROD_W-1], p_ca_r} - {p_ac_r[PROD_W-1], p_ac_r};
    end
  end

  // stage 3 into divider slot 0: magnitudes and epsilon test
  logic [PROD_W:0] dm_nxt, xm_nxt, ym_nxt;
  assign dm_nxt = d_r[PROD_W]  ? -d_r  : d_r;
  assign xm_nxt = dx_r[PROD_W] ? -dx_r : dx_r;
  assign ym_nxt = dy_r[PROD_W] ? -dy_r : dy_r;

  logic              dv_v_r     [0:DIV_STEPS];
  logic              dv_found_r [0:DIV_STEPS];
  logic              dv_xs_r    [0:DIV_STEPS];
  logic              dv_ys_r    [0:DIV_STEPS];
  logic [PROD_W-1:0] dv_den_r   [0:DIV_STEPS];
  logic [PROD_W-1:0] dv_xn_r    [0:DIV_STEPS];
  logic [PROD_W-1:0] dv_yn_r    [0:DIV_STEPS];
  logic [PROD_W-1:0] dv_xr_r    [0:DIV_STEPS];
  logic [PROD_W-1:0] dv_yr_r    [0:DIV_STEPS];
  logic [COEF_W:0]   dv_xq_r    [0:DIV_STEPS];
  logic [COEF_W:0]   dv_yq_r    [0:DIV_STEPS];
  logic              dv_xsat_r  [0:DIV_STEPS];
  logic              dv_ysat_r  [0:DIV_STEPS];

  // one restoring step per stage
  logic [PROD_W:0]   xrr [0:DIV_STEPS-1];
  logic [PROD_W:0]   yrr [0:DIV_STEPS-1];
  logic              xge [0:DIV_STEPS-1];
  logic              yge [0:DIV_STEPS-1];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      xrr[k] = {dv_xr_r[k], dv_xn_r[k][PROD_W-1]};
      yrr[k] = {dv_yr_r[k], dv_yn_r[k][PROD_W-1]};
      xge[k] = xrr[k] >= {1'b0, dv_den_r[k]};
      yge[k] = yrr[k] >= {1'b0, dv_den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      dv_v_r[0] <= s2_v_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_found_r[0] <= dm_nxt > {{(PROD_W+1-COEF_W){1'b0}}, eps_r};
      dv_xs_r[0]    <= dx_r[PROD_W] != d_r[PROD_W];
      dv_ys_r[0]    <= dy_r[PROD_W] != d_r[PROD_W];
      dv_den_r[0]   <= dm_nxt[PROD_W-1:0];
      dv_xn_r[0]    <= xm_nxt[PROD_W-1:0];
      dv_yn_r[0]    <= ym_nxt[PROD_W-1:0];
      dv_xr_r[0]    <= '0;
      dv_yr_r[0]    <= '0;
      dv_xq_r[0]    <= '0;
      dv_yq_r[0]    <= '0;
      dv_xsat_r[0]  <= 1'b0;
      dv_ysat_r[0]  <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_found_r[k+1] <= dv_found_r[k];
        dv_xs_r[k+1]    <= dv_xs_r[k];
        dv_ys_r[k+1]    <= dv_ys_r[k];
        dv_den_r[k+1]   <= dv_den_r[k];
        dv_xn_r[k+1]    <= {dv_xn_r[k][PROD_W-2:0], 1'b0};
        dv_yn_r[k+1]    <= {dv_yn_r[k][PROD_W-2:0], 1'b0};
        dv_xr_r[k+1]    <= xge[k] ? PROD_W'(xrr[k] - {1'b0, dv_den_r[k]})
                                  : xrr[k][PROD_W-1:0];
        dv_yr_r[k+1]    <= yge[k] ? PROD_W'(yrr[k] - {1'b0, dv_den_r[k]})
                                  : yrr[k][PROD_W-1:0];
        dv_xq_r[k+1]    <= {dv_xq_r[k][COEF_W-1:0], xge[k]};
        dv_yq_r[k+1]    <= {dv_yq_r[k][COEF_W-1:0], yge[k]};
        // once the quotient reaches 2^32 it can only grow, so remember that
        dv_xsat_r[k+1]  <= dv_xsat_r[k] || dv_xq_r[k][COEF_W];
        dv_ysat_r[k+1]  <= dv_ysat_r[k] || dv_yq_r[k][COEF_W];
      end
    end
  end

  // final saturation to the coordinate range
  logic              x_big, y_big, x_neg, y_neg, x_ovf, y_ovf;
  logic [COEF_W-1:0] x_mag, y_mag, x_val, y_val;

  always_comb begin
    x_big = dv_xsat_r[DIV_STEPS] || dv_xq_r[DIV_STEPS][COEF_W];
    y_big = dv_ysat_r[DIV_STEPS] || dv_yq_r[DIV_STEPS][COEF_W];
    x_mag = dv_xq_r[DIV_STEPS][COEF_W-1:0];
    y_mag = dv_yq_r[DIV_STEPS][COEF_W-1:0];
    x_neg = dv_xs_r[DIV_STEPS] && (x_big || x_mag != '0);
    y_neg = dv_ys_r[DIV_STEPS] && (y_big || y_mag != '0);
    if (x_neg) begin
      x_ovf = x_big || x_mag > Q_MAX_NEG;
      x_val = x_ovf ? Q_MAX_NEG : -x_mag;
    end else begin
      x_ovf = x_big || x_mag > Q_MAX_POS;
      x_val = x_ovf ? Q_MAX_POS : x_mag;
    end
    if (y_neg) begin
      y_ovf = y_big || y_mag > Q_MAX_NEG;
      y_val = y_ovf ? Q_MAX_NEG : -y_mag;
    end else begin
      y_ovf = y_big || y_mag > Q_MAX_POS;
      y_val = y_ovf ? Q_MAX_POS : y_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_found_r[DIV_STEPS]) begin
        out_tdata <= {y_val, x_val};
        out_tuser <= {x_ovf || y_ovf, 1'b1};
      end else begin
        out_tdata <= '0;
        out_tuser <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* verif/line_intersection_cramer_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the two-line intersection block
// depends on lic_pkg and line_intersection_cramer
module line_intersection_cramer_tb import lic_pkg::*;;

  typedef struct packed {
    logic [31:0] a1, b1, c1, a2, b2, c2;
  } line_pair_t;

  typedef struct packed {
    logic        found;
    logic [31:0] x;
    logic [31:0] y;
    logic        ovf;
  } cross_t;

  typedef struct {
    line_pair_t lp;
    logic       has_exp;
    cross_t     exp;
  } vec_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [31:0]   cfg_wdata = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [191:0]  in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [63:0]   out_tdata;
  logic [1:0]    out_tuser;

  line_intersection_cramer u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  logic [31:0] eps_shadow;
  cross_t      cross_q[$];
  vec_t        table_v[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          hold_off = 0;
  bit          stim_done = 0;
  localparam int WATCHDOG = 20000;

  function automatic logic signed [64:0] sx65(logic [31:0] v);
    return {{33{v[31]}}, v};
  endfunction

  function automatic logic [31:0] saturate_q(logic [80:0] mag, bit neg, ref bit ovf);
    if (neg) begin
      if (mag > 81'h80000000) begin
        ovf = 1;
        return Q_MAX_NEG;
      end
      return 32'(-mag[32:0]);
    end
    if (mag > 81'h7FFFFFFF) begin
      ovf = 1;
      return Q_MAX_POS;
    end
    return mag[31:0];
  endfunction

  function automatic cross_t solve_cramer(line_pair_t lp, logic [31:0] eps);
    logic signed [64:0] det, dx, dy;
    logic [64:0]        dm, xm, ym;
    logic [80:0]        qx, qy;
    bit                 ovf;
    cross_t             r;
    ovf = 0;
    det = sx65(lp.a1) * sx65(lp.b2) - sx65(lp.b1) * sx65(lp.a2);
    dx  = sx65(lp.b1) * sx65(lp.c2) - sx65(lp.c1) * sx65(lp.b2);
    dy  = sx65(lp.c1) * sx65(lp.a2) - sx65(lp.a1) * sx65(lp.c2);
    dm = det[64] ? 65'(-det) : 65'(det);
    if (dm <= {33'd0, eps}) return '0;
    xm = dx[64] ? 65'(-dx) : 65'(dx);
    ym = dy[64] ? 65'(-dy) : 65'(dy);
    qx = ({16'd0, xm} << FRAC_BITS) / {16'd0, dm};
    qy = ({16'd0, ym} << FRAC_BITS) / {16'd0, dm};
    r.found = 1'b1;
    r.x = saturate_q(qx, (dx[64] != det[64]) && qx != 0, ovf);
    r.y = saturate_q(qy, (dy[64] != det[64]) && qy != 0, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000) << 8;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
    endcase
  endfunction

  function automatic line_pair_t rand_pair();
    line_pair_t lp;
    int         k;
    lp = {rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    // near-parallel: second line a scaled copy of the first, maybe nudged
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, 3);
      lp.a2 = lp.a1 * k + $urandom_range(0, 3);
      lp.b2 = lp.b1 * k;
    end
    return lp;
  endfunction

  task automatic add_row(logic [31:0] a1, b1, c1, a2, b2, c2, bit chk, cross_t e);
    vec_t v;
    v.lp = {a1, b1, c1, a2, b2, c2};
    v.has_exp = chk;
    v.exp = e;
    table_v.push_back(v);
  endtask

  task automatic send_item(line_pair_t lp);
    in_tdata <= {lp.c2, lp.b2, lp.a2, lp.c1, lp.b1, lp.a1};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    cross_q.push_back(solve_cramer(lp, eps_shadow));
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  task automatic drain_then_write(logic [31:0] eps);
    in_tvalid <= 1'b0;
    while (cross_q.size() != 0) @(negedge clk);
    repeat (90) @(negedge clk);
    cfg_wdata <= eps;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    eps_shadow = eps;
  endtask

  // result side: random backpressure, one long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 4) != 0) || ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    cross_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[31:0], out_tdata[63:32], out_tuser[1]};
      if (cross_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = cross_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%b x=%h y=%h ovf=%b got found=%b x=%h y=%h ovf=%b",
                     want.found, want.x, want.y, want.ovf,
                     got.found, got.x, got.y, got.ovf);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int     n;
    cross_t z;
    z = '0;
    eps_shadow = EPS_RESET;
    // directed rows: expected typed in for obvious ones
    add_row(32'h10000, 0, 32'hFFFF0000, 0, 32'h10000, 32'hFFFE0000, 1'b1,
            {1'b1, 32'h10000, 32'h20000, 1'b0});
    add_row(0, 0, 0, 0, 0, 0, 1'b1, z);
    add_row(32'h10000, 32'h10000, 0, 32'h20000, 32'h20000, 32'h10000, 1'b1, z);
    add_row(1, 0, 32'h7FFFFFFF, 0, 1, 32'h80000000, 1'b0, z);
    add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 1'b0, z);
    add_row(32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, z);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
            32'h80000000, 1'b0, z);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 1'b0, z);
    add_row(32'h10000, 32'h10000, 32'h30000, 32'h10000, 32'hFFFF0000, 32'h10000, 1'b0, z);
    add_row(32'h30000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h10000, 1'b0, z);
    add_row(1, 0, 0, 0, 2, 0, 1'b0, z);
    add_row(1, 0, 32'h10000, 0, 2, 32'hFFFF0000, 1'b0, z);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (table_v[i]) begin
      if (table_v[i].has_exp && solve_cramer(table_v[i].lp, eps_shadow) !== table_v[i].exp) begin
        mismatches++;
        $display("directed row %0d disagrees with typed expectation", i);
      end
      send_item(table_v[i].lp);
    end
    drain_then_write(32'h0);
    send_item({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0});
    send_item({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    // long receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 120; k++) send_item(rand_pair());
    join
    drain_then_write(32'hFFFFFFFF);
    for (int k = 0; k < 150; k++) send_item(rand_pair());
    drain_then_write($urandom());
    for (int k = 0; k < 400; k++) send_item(rand_pair());
    drain_then_write(32'h0001_0000);
    for (int k = 0; k < 400; k++) send_item(rand_pair());
    drain_then_write(EPS_RESET);
    n = 600;
    for (int k = 0; k < n; k++) send_item(rand_pair());
    in_tvalid <= 1'b0;
    while (cross_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
